// File: sv/rafs_pkg.sv
// Package for the register allocator with FIFO eviction.
// Holds op and status codes, list control codes and the channel item types.
// No dependencies.
package rafs_pkg;

   // Defaults for the top level parameters
   localparam int NUM_REGS_DEF   = 16;
   localparam int OWNER_BITS_DEF = 8;

   // Operation codes
   localparam logic [2:0] OP_ALLOC      = 3'd0;
   localparam logic [2:0] OP_ALLOC_ANON = 3'd1;
   localparam logic [2:0] OP_CLAIM      = 3'd2;
   localparam logic [2:0] OP_FREE_OWNER = 3'd3;
   localparam logic [2:0] OP_FREE_REG   = 3'd4;

   // Result status codes
   localparam logic [1:0] ST_FREE  = 2'd0;
   localparam logic [1:0] ST_HELD  = 2'd1;
   localparam logic [1:0] ST_EVICT = 2'd2;
   localparam logic [1:0] ST_NONE  = 2'd3;

   // Age list removal selects
   localparam logic [1:0] RM_NONE  = 2'd0;
   localparam logic [1:0] RM_OWNER = 2'd1;
   localparam logic [1:0] RM_REG   = 2'd2;
   localparam logic [1:0] RM_HEAD  = 2'd3;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] owner_id;
      logic       has_preference;
      logic [3:0] reg_number;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  granted_reg;
      logic [7:0]  evicted_owner;
      logic [15:0] busy_mask;
      logic [15:0] used_mask;
   } rsp_type;

   // Update request from the decision logic to the age list
   typedef struct packed {
      logic [1:0] rm_sel;
      logic       append;
   } list_ctl_type;

   // Lookup flags from the age list
   typedef struct packed {
      logic own_hit;
      logic reg_hit;
      logic not_empty;
   } list_hit_type;

endpackage

// File: sv/rafs_age_list.sv
// Age-ordered list of owner/register pairs, oldest at entry 0.
// Associative lookup by owner and by register, removal with shift, append.
// Depends on rafs_pkg.
module rafs_age_list
   import rafs_pkg::*;
#(
   parameter int NUM_REGS   = NUM_REGS_DEF,
   parameter int OWNER_BITS = OWNER_BITS_DEF,
   localparam int RW        = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1,
   localparam int CNTW      = $clog2(NUM_REGS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  update,
   input  logic [OWNER_BITS-1:0] owner_key,
   input  logic [RW-1:0]         reg_key,
   input  list_ctl_type          ctl,
   input  logic [RW-1:0]         app_reg,
   output list_hit_type          hit,
   output logic [RW-1:0]         own_reg,
   output logic [OWNER_BITS-1:0] reg_owner,
   output logic [RW-1:0]         head_reg,
   output logic [OWNER_BITS-1:0] head_owner
);

   logic [OWNER_BITS-1:0] owner_ff [NUM_REGS];
   logic [RW-1:0]         reg_ff   [NUM_REGS];
   logic [CNTW-1:0]       count_ff;
   logic [CNTW-1:0]       count_in;

   logic [NUM_REGS-1:0] own_match, reg_match, own_oh, reg_oh, rm_oh, shift_ge;
   logic [CNTW-1:0]     cnt_rm;
   logic                app_ok;

   // Compare every live entry against both keys
   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         own_match[i] = (CNTW'(i) < count_ff) && (owner_ff[i] == owner_key);
         reg_match[i] = (CNTW'(i) < count_ff) && (reg_ff[i] == reg_key);
      end
   end

   // Keep the oldest match only
   assign own_oh = own_match & (~own_match + NUM_REGS'(1));
   assign reg_oh = reg_match & (~reg_match + NUM_REGS'(1));

   // Read out matched fields
   always_comb begin
      own_reg   = '0;
      reg_owner = '0;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (own_oh[i]) begin
            own_reg = own_reg | reg_ff[i];
         end
         if (reg_oh[i]) begin
            reg_owner = reg_owner | owner_ff[i];
         end
      end
   end

   assign hit.own_hit   = |own_oh;
   assign hit.reg_hit   = |reg_oh;
   assign hit.not_empty = (count_ff != '0);
   assign head_reg      = reg_ff[0];
   assign head_owner    = owner_ff[0];

   // Select the entry to drop
   always_comb begin
      case (ctl.rm_sel)
         RM_OWNER: rm_oh = own_oh;
         RM_REG:   rm_oh = reg_oh;
         RM_HEAD:  rm_oh = hit.not_empty ? NUM_REGS'(1) : '0;
         default:  rm_oh = '0;
      endcase
   end

   // Entries at and above the dropped one move down by one
   assign shift_ge = (rm_oh != '0) ? ~(rm_oh - NUM_REGS'(1)) : '0;
   assign cnt_rm   = count_ff - CNTW'(rm_oh != '0);
   assign app_ok   = ctl.append && (cnt_rm < CNTW'(NUM_REGS));
   assign count_in = cnt_rm + CNTW'(app_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (update) begin
         count_ff <= count_in;
      end
   end

   // Entry storage: shift down, then write the new tail
   for (genvar g = 0; g < NUM_REGS; g++) begin : g_entry
      logic [OWNER_BITS-1:0] owner_in;
      logic [RW-1:0]         reg_in;

      always_comb begin
         owner_in = owner_ff[g];
         reg_in   = reg_ff[g];
         if (shift_ge[g]) begin
            owner_in = owner_ff[(g + 1 < NUM_REGS) ? g + 1 : g];
            reg_in   = reg_ff[(g + 1 < NUM_REGS) ? g + 1 : g];
         end
         if (app_ok && (cnt_rm == CNTW'(g))) begin
            owner_in = owner_key;
            reg_in   = app_reg;
         end
      end

      always_ff @(posedge clock) begin
         if (update) begin
            owner_ff[g] <= owner_in;
            reg_ff[g]   <= reg_in;
         end
      end
   end

endmodule

// File: sv/register_allocator_fifo_spill.sv
// Top level of the register allocator with busy/used bitmaps and FIFO eviction.
// Decision logic and result register; the owner list lives in rafs_age_list.
// Depends on rafs_pkg and rafs_age_list.
//
//   channel | ports                          | payload
//   --------+--------------------------------+-----------------
//   request | req_valid, req_ready, req_data | req_type (op, owner, reg)
//   result  | rsp_valid, rsp_ready, rsp_data | rsp_type (status, masks)
//
// One item per cycle unless a held result stalls input: lookup, choice and
// list update end at the accept; the result shows in the cycle after it.
// The next item sees the state left by the previous one, set at the accept.
// A held result blocks input only while rsp_ready is low.
// Reset clears the bitmaps and empties the owner list at once.
module register_allocator_fifo_spill
   import rafs_pkg::*;
#(
   parameter int NUM_REGS   = NUM_REGS_DEF,
   parameter int OWNER_BITS = OWNER_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   logic [NUM_REGS-1:0] busy_ff, busy_in, used_ff, used_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   logic                accept;

   logic [OWNER_BITS-1:0] owner_key, reg_owner, head_owner, evicted;
   logic [RW-1:0]         reg_key, own_reg, head_reg, granted, chosen;
   list_hit_type          hit;
   list_ctl_type          ctl;
   logic [1:0]            status;

   logic                reg_ok, pref_free, any_free;
   logic [NUM_REGS-1:0] free_vec, free_oh;
   logic [RW-1:0]       low_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   assign owner_key = OWNER_BITS'(req_data.owner_id);
   assign reg_key   = RW'(req_data.reg_number);
   assign reg_ok    = {2'b00, req_data.reg_number} < 6'(NUM_REGS);

   // Lowest free register
   assign free_vec = ~busy_ff;
   assign free_oh  = free_vec & (~free_vec + NUM_REGS'(1));
   assign any_free = |free_vec;
   always_comb begin
      low_free = '0;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (free_oh[i]) begin
            low_free = low_free | RW'(i);
         end
      end
   end

   assign pref_free = req_data.has_preference && reg_ok && !busy_ff[reg_key];
   assign chosen    = pref_free ? reg_key : low_free;

   rafs_age_list #(
      .NUM_REGS   (NUM_REGS),
      .OWNER_BITS (OWNER_BITS)
   ) u_list (
      .clock      (clock),
      .reset      (reset),
      .update     (accept),
      .owner_key  (owner_key),
      .reg_key    (reg_key),
      .ctl        (ctl),
      .app_reg    (granted),
      .hit        (hit),
      .own_reg    (own_reg),
      .reg_owner  (reg_owner),
      .head_reg   (head_reg),
      .head_owner (head_owner)
   );

   // Decide the outcome of one item
   always_comb begin
      status     = ST_NONE;
      granted    = '0;
      evicted    = '0;
      busy_in    = busy_ff;
      used_in    = used_ff;
      ctl.rm_sel = RM_NONE;
      ctl.append = 1'b0;
      case (req_data.op)
         OP_ALLOC, OP_ALLOC_ANON: begin
            if ((req_data.op == OP_ALLOC) && hit.own_hit) begin
               status  = ST_HELD;
               granted = own_reg;
            end else begin
               if (any_free) begin
                  status           = ST_FREE;
                  granted          = chosen;
                  busy_in[chosen]  = 1'b1;
                  used_in[chosen]  = 1'b1;
               end else if (hit.not_empty) begin
                  status     = ST_EVICT;
                  granted    = head_reg;
                  evicted    = head_owner;
                  ctl.rm_sel = RM_HEAD;
               end
               ctl.append = (status != ST_NONE) && (req_data.op == OP_ALLOC);
            end
         end
         OP_CLAIM: begin
            if (reg_ok) begin
               status = ST_FREE;
               if (busy_ff[reg_key] && hit.reg_hit) begin
                  status     = ST_EVICT;
                  evicted    = reg_owner;
                  ctl.rm_sel = RM_REG;
               end
               busy_in[reg_key] = 1'b1;
               used_in[reg_key] = 1'b1;
               granted          = reg_key;
            end
         end
         OP_FREE_OWNER: begin
            if (hit.own_hit) begin
               status           = ST_HELD;
               granted          = own_reg;
               busy_in[own_reg] = 1'b0;
               ctl.rm_sel       = RM_OWNER;
            end
         end
         OP_FREE_REG: begin
            if (reg_ok) begin
               busy_in[reg_key] = 1'b0;
               if (hit.reg_hit) begin
                  status     = ST_EVICT;
                  evicted    = reg_owner;
                  granted    = reg_key;
                  ctl.rm_sel = RM_REG;
               end else if (busy_ff[reg_key]) begin
                  status  = ST_HELD;
                  granted = reg_key;
               end
            end
         end
         default: begin
            status = ST_NONE;
         end
      endcase
   end

   // Advance bitmaps and hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff      <= busy_in;
            used_ff      <= used_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff.status        <= status;
         rsp_ff.granted_reg   <= 4'(granted);
         rsp_ff.evicted_owner <= 8'(evicted);
         rsp_ff.busy_mask     <= 16'(busy_in);
         rsp_ff.used_mask     <= 16'(used_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
